// ===== hw/rtl/pspes_pkg.sv =====
// ---------------------------------------------------------------------------
// pspes_pkg: shared types and constants of the PS/PES packetizer
// Field widths, the command word passed from the classifier to the emitter,
// fixed header bytes and the timestamp residue helper used for the SCR
// extension.
// ---------------------------------------------------------------------------
package pspes_pkg;

    // Limits of the chunking logic.
    localparam int unsigned MAX_CHUNK = 65522;
    localparam int unsigned MAX_FRAME = 1048576;

    // Field widths.
    localparam int unsigned FRAME_LEN_W = 21;
    localparam int unsigned CHUNK_W     = 16;
    localparam int unsigned TS_W        = 33;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned COUNT_W     = 3;

    // Command queue between classifier and emitter.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // PTS mod 100: a residue sum over the nibbles, then a reciprocal multiply.
    localparam int unsigned TSUM_W      = 13;
    localparam int unsigned RECIP       = 10486;
    localparam int unsigned RECIP_W     = 14;
    localparam int unsigned RECIP_SHIFT = 20;
    localparam int unsigned QUOT_W      = 6;
    localparam int unsigned EXT_W       = 7;
    localparam int unsigned SCR_EXT_W   = 9;
    localparam int unsigned MOD_BASE    = 100;

    // PES_packet_length is the chunk length plus the remaining header bytes.
    localparam int unsigned PES_LEN_OFFSET = 13;

    // Header word counts and the byte count of each header's last word.
    localparam int unsigned IDX_W            = 5;
    localparam int unsigned KEY_HDR_WORDS    = 19;
    localparam int unsigned PLAIN_HDR_WORDS  = 9;
    localparam int unsigned KEY_LAST_COUNT   = 3;
    localparam int unsigned PLAIN_LAST_COUNT = 1;
    localparam int unsigned FULL_COUNT       = 4;

    // Request codes of the input word.
    localparam logic REQ_FRAME_START = 1'b0;
    localparam logic REQ_PAYLOAD     = 1'b1;

    // PES stream ids.
    localparam logic [7:0] SID_VIDEO = 8'hE0;
    localparam logic [7:0] SID_AUDIO = 8'hC0;

    // Fixed system header (18 bytes) and program stream map (24 bytes).
    localparam logic [143:0] SYS_HDR = 144'h000001BB000C8186A105E17FC0C200E0E800;
    localparam logic [191:0] PSM_HDR =
        192'h000001BC0012E0FF0000000890C000001BE0000045BDDCF4;

    // 16^i mod 100 for the nine nibble positions of a 33-bit timestamp,
    // position 0 in the lowest seven bits.
    localparam int unsigned NIB_RES_W = 7;
    localparam logic [9*NIB_RES_W-1:0] NIB_RES = {7'd96, 7'd56, 7'd16, 7'd76, 7'd36,
                                                  7'd96, 7'd56, 7'd16, 7'd1};

    // Kinds of work handed to the emitter.
    typedef enum logic [1:0] {
        CMD_STRAY,
        CMD_BYTE,
        CMD_CHUNK
    } cmd_kind_t;

    // One queued command.
    typedef struct packed {
        cmd_kind_t           kind;
        logic [BYTE_W-1:0]   data_byte;
        logic                frame_end;
        logic                key;
        logic [TS_W-1:0]     ts;
        logic [TSUM_W-1:0]   tsum;
        logic [CHUNK_W-1:0]  pes_len;
    } pes_cmd_t;

    // Sum of nibble residues; the result is congruent to ts modulo 100.
    function automatic logic [TSUM_W-1:0] ts_residue_sum(input logic [TS_W-1:0] ts);
        logic [TSUM_W-1:0] acc;
        acc = ts[32] ? TSUM_W'(NIB_RES[8*NIB_RES_W +: NIB_RES_W]) : '0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + TSUM_W'(ts[4*i +: 4]) * TSUM_W'(NIB_RES[NIB_RES_W*i +: NIB_RES_W]);
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/pspes_front.sv =====
// ---------------------------------------------------------------------------
// pspes_front: input classifier
// Tracks the open frame and chunk, and turns each payload byte into a
// command for the emitter: a stray drop, a plain byte, or a chunk opener.
// ---------------------------------------------------------------------------
module pspes_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [pspes_pkg::FRAME_LEN_W-1:0] frame_length,
    input  logic [pspes_pkg::TS_W-1:0]        pts,
    input  logic                              key_frame,
    input  logic [pspes_pkg::BYTE_W-1:0]      data_byte,
    input  logic                              q_full,
    output logic                              push,
    output pspes_pkg::pes_cmd_t               push_cmd
);

    logic [pspes_pkg::FRAME_LEN_W-1:0] frame_left_reg, frame_left_next;
    logic [pspes_pkg::CHUNK_W-1:0]     chunk_left_reg, chunk_left_next;
    logic [pspes_pkg::TS_W-1:0]        ts_reg, ts_next;
    logic [pspes_pkg::TSUM_W-1:0]      tsum_reg, tsum_next;
    logic                              key_reg, key_next;
    logic                              open_reg, open_next;

    logic                              accept;
    logic [pspes_pkg::FRAME_LEN_W-1:0] len_sat;
    logic [pspes_pkg::CHUNK_W-1:0]     chunk_len;
    logic                              chunk_first;
    logic                              last_byte;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Frame length saturates at the largest frame.
    assign len_sat = (frame_length > pspes_pkg::FRAME_LEN_W'(pspes_pkg::MAX_FRAME))
                   ? pspes_pkg::FRAME_LEN_W'(pspes_pkg::MAX_FRAME) : frame_length;

    // Length of a chunk that opens now.
    assign chunk_first = (chunk_left_reg == '0);
    assign chunk_len   = (frame_left_reg > pspes_pkg::FRAME_LEN_W'(pspes_pkg::MAX_CHUNK))
                       ? pspes_pkg::CHUNK_W'(pspes_pkg::MAX_CHUNK)
                       : frame_left_reg[pspes_pkg::CHUNK_W-1:0];
    assign last_byte   = (frame_left_reg == pspes_pkg::FRAME_LEN_W'(1));

    // Frame state update and command build.
    always_comb
    begin
        frame_left_next = frame_left_reg;
        chunk_left_next = chunk_left_reg;
        ts_next         = ts_reg;
        tsum_next       = tsum_reg;
        key_next        = key_reg;
        open_next       = open_reg;
        push            = 1'b0;

        push_cmd           = '0;
        push_cmd.kind      = pspes_pkg::CMD_BYTE;
        push_cmd.data_byte = data_byte;
        push_cmd.frame_end = last_byte;
        push_cmd.key       = key_reg;
        push_cmd.ts        = ts_reg;
        push_cmd.tsum      = tsum_reg;
        push_cmd.pes_len   = chunk_len + pspes_pkg::CHUNK_W'(pspes_pkg::PES_LEN_OFFSET);

        if (accept) begin
            if (req_type == pspes_pkg::REQ_FRAME_START) begin
                // A new frame drops whatever frame was still open.
                frame_left_next = len_sat;
                chunk_left_next = '0;
                ts_next         = pts;
                tsum_next       = pspes_pkg::ts_residue_sum(pts);
                key_next        = key_frame;
                open_next       = (len_sat != '0);
            end else if (!open_reg || frame_left_reg == '0) begin
                // Stray byte with no frame open.
                open_next     = 1'b0;
                push          = 1'b1;
                push_cmd.kind = pspes_pkg::CMD_STRAY;
            end else begin
                push = 1'b1;
                if (chunk_first) begin
                    push_cmd.kind   = pspes_pkg::CMD_CHUNK;
                    chunk_left_next = chunk_len - pspes_pkg::CHUNK_W'(1);
                end else begin
                    chunk_left_next = chunk_left_reg - pspes_pkg::CHUNK_W'(1);
                end
                frame_left_next = frame_left_reg - pspes_pkg::FRAME_LEN_W'(1);
                if (last_byte) begin
                    open_next       = 1'b0;
                    chunk_left_next = '0;
                end
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_left_reg <= '0;
            chunk_left_reg <= '0;
            ts_reg         <= '0;
            tsum_reg       <= '0;
            key_reg        <= 1'b0;
            open_reg       <= 1'b0;
        end else begin
            frame_left_reg <= frame_left_next;
            chunk_left_reg <= chunk_left_next;
            ts_reg         <= ts_next;
            tsum_reg       <= tsum_next;
            key_reg        <= key_next;
            open_reg       <= open_next;
        end
    end

endmodule

// ===== hw/rtl/pspes_queue.sv =====
// ---------------------------------------------------------------------------
// pspes_queue: command queue
// A short first-in first-out buffer of commands between the classifier and
// the emitter, with the head entry readable in place.
// ---------------------------------------------------------------------------
module pspes_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pspes_pkg::pes_cmd_t push_cmd,
    input  logic                pop,
    output pspes_pkg::pes_cmd_t head,
    output logic                head_valid,
    output logic                full
);

    pspes_pkg::pes_cmd_t entry_reg [pspes_pkg::QUEUE_DEPTH];

    logic [pspes_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [pspes_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [pspes_pkg::QCNT_W-1:0] count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == pspes_pkg::QCNT_W'(pspes_pkg::QUEUE_DEPTH));

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + pspes_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + pspes_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + pspes_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - pspes_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/pspes_back.sv =====
// ---------------------------------------------------------------------------
// pspes_back: stream emitter
// Expands the command at the head of the queue into output words: the
// chunk headers one word per cycle while the output is not stalled, then the
// payload byte, behind an output register; a stray byte becomes a status word.
// ---------------------------------------------------------------------------
module pspes_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pspes_pkg::pes_cmd_t           head,
    input  logic                          head_valid,
    output logic                          pop,
    input  logic                          audio_select,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pspes_pkg::DATA_W-1:0]  out_data,
    output logic [pspes_pkg::COUNT_W-1:0] byte_count,
    output logic                          frame_end,
    output logic                          status,
    output logic                          last_of_run
);

    localparam int unsigned KEY_BITS   = 32 * pspes_pkg::KEY_HDR_WORDS;
    localparam int unsigned PLAIN_BITS = 32 * pspes_pkg::PLAIN_HDR_WORDS;
    localparam int unsigned PROD_W     = pspes_pkg::TSUM_W + pspes_pkg::RECIP_W;

    logic [pspes_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [pspes_pkg::QUOT_W-1:0] quot_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [pspes_pkg::DATA_W-1:0] out_data_reg;
    logic [pspes_pkg::COUNT_W-1:0] byte_count_reg;
    logic                         frame_end_reg;
    logic                         status_reg;
    logic                         last_reg;

    logic [PROD_W-1:0]               recip_prod;
    logic [pspes_pkg::EXT_W-1:0]     scr_ext;
    logic [pspes_pkg::SCR_EXT_W-1:0] scr_ext9;
    logic [7:0]                      pes_sid;
    logic [111:0]                    pack_hdr;
    logic [151:0]                    pes_hdr;
    logic [KEY_BITS-1:0]             key_vec;
    logic [PLAIN_BITS-1:0]           plain_vec;
    logic [pspes_pkg::DATA_W-1:0]    key_words   [pspes_pkg::KEY_HDR_WORDS];
    logic [pspes_pkg::DATA_W-1:0]    plain_words [pspes_pkg::PLAIN_HDR_WORDS];
    logic [pspes_pkg::IDX_W-1:0]     hdr_words;
    logic [pspes_pkg::COUNT_W-1:0]   hdr_last_count;

    logic                          adv;
    logic [pspes_pkg::DATA_W-1:0]  word_data;
    logic [pspes_pkg::COUNT_W-1:0] word_count;
    logic                          word_fend;
    logic                          word_status;
    logic                          word_last;

    // Quotient of the residue sum by 100, taken while the first word goes out.
    assign recip_prod = PROD_W'(head.tsum) * PROD_W'(pspes_pkg::RECIP);
    assign scr_ext    = pspes_pkg::EXT_W'(head.tsum
                      - pspes_pkg::TSUM_W'(quot_reg) * pspes_pkg::TSUM_W'(pspes_pkg::MOD_BASE));
    assign scr_ext9   = pspes_pkg::SCR_EXT_W'(scr_ext);
    assign pes_sid    = audio_select ? pspes_pkg::SID_AUDIO : pspes_pkg::SID_VIDEO;

    // Pack header with SCR base and extension, mux rate 255.
    assign pack_hdr = {32'h000001BA, 2'b01, head.ts[32:30], 1'b1, head.ts[29:15], 1'b1,
                       head.ts[14:0], 1'b1, scr_ext9, 1'b1, 22'd255, 2'b11, 5'h1F, 3'b000};

    // PES header with PTS equal to DTS.
    assign pes_hdr = {24'h000001, pes_sid, head.pes_len, 8'h80, 8'hC0, 8'h0A,
                      4'b0011, head.ts[32:30], 1'b1, head.ts[29:15], 1'b1,
                      head.ts[14:0], 1'b1,
                      4'b0001, head.ts[32:30], 1'b1, head.ts[29:15], 1'b1,
                      head.ts[14:0], 1'b1};

    assign key_vec   = {pack_hdr, pspes_pkg::SYS_HDR, pspes_pkg::PSM_HDR, pes_hdr, 8'h00};
    assign plain_vec = {pack_hdr, pes_hdr, 24'h000000};

    // Split the header streams into words, first byte most significant.
    for (genvar w = 0; w < pspes_pkg::KEY_HDR_WORDS; w++) begin : g_key_words
        assign key_words[w] = key_vec[KEY_BITS-1-32*w -: 32];
    end
    for (genvar w = 0; w < pspes_pkg::PLAIN_HDR_WORDS; w++) begin : g_plain_words
        assign plain_words[w] = plain_vec[PLAIN_BITS-1-32*w -: 32];
    end

    assign hdr_words      = head.key ? pspes_pkg::IDX_W'(pspes_pkg::KEY_HDR_WORDS)
                                     : pspes_pkg::IDX_W'(pspes_pkg::PLAIN_HDR_WORDS);
    assign hdr_last_count = head.key ? pspes_pkg::COUNT_W'(pspes_pkg::KEY_LAST_COUNT)
                                     : pspes_pkg::COUNT_W'(pspes_pkg::PLAIN_LAST_COUNT);

    assign adv = head_valid && (!out_valid_reg || out_ready);

    // Word selection for the head command.
    always_comb
    begin
        word_data   = {head.data_byte, 24'h000000};
        word_count  = pspes_pkg::COUNT_W'(1);
        word_fend   = head.frame_end;
        word_status = 1'b0;
        word_last   = 1'b1;
        idx_next    = idx_reg;
        pop         = 1'b0;

        unique case (head.kind)
            pspes_pkg::CMD_STRAY:
            begin
                word_data   = '0;
                word_count  = '0;
                word_fend   = 1'b0;
                word_status = 1'b1;
                pop         = adv;
            end
            pspes_pkg::CMD_BYTE:
            begin
                pop = adv;
            end
            pspes_pkg::CMD_CHUNK:
            begin
                if (idx_reg == hdr_words) begin
                    pop = adv;
                    if (adv) begin
                        idx_next = '0;
                    end
                end else begin
                    word_data  = head.key ? key_words[idx_reg]
                                          : plain_words[idx_reg[pspes_pkg::IDX_W-2:0]];
                    word_count = (idx_reg == hdr_words - pspes_pkg::IDX_W'(1))
                               ? hdr_last_count
                               : pspes_pkg::COUNT_W'(pspes_pkg::FULL_COUNT);
                    word_fend  = 1'b0;
                    word_last  = 1'b0;
                    if (adv) begin
                        idx_next = idx_reg + pspes_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                pop = adv;
            end
        endcase
    end

    // Output valid follows the advance and the consumer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Quotient register and output payload.
    always_ff @(posedge clk)
    begin
        if (idx_reg == '0) begin
            quot_reg <= recip_prod[pspes_pkg::RECIP_SHIFT +: pspes_pkg::QUOT_W];
        end
        if (adv) begin
            out_data_reg   <= word_data;
            byte_count_reg <= word_count;
            frame_end_reg  <= word_fend;
            status_reg     <= word_status;
            last_reg       <= word_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_data    = out_data_reg;
    assign byte_count  = byte_count_reg;
    assign frame_end   = frame_end_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;

endmodule

// ===== hw/rtl/h264_ps_pes_packetizer.sv =====
// ---------------------------------------------------------------------------
// h264_ps_pes_packetizer: program stream PES packetizer
// Cuts frames into chunks and wraps each chunk in pack, optional system
// and stream map, and PES headers; headers go four bytes to a word, payload one.
// ---------------------------------------------------------------------------
//  Channel   Handshake               Carries
//  input     in_valid / in_ready     req_type, frame_length, pts, key_frame, data_byte
//  output    out_valid / out_ready   out_data, byte_count, frame_end, status, last_of_run
//  config    cfg_wr_en               cfg_wr_data (audio_select)
//
// The classifier takes one word per cycle while the four-entry command queue
// has room. A plain payload byte passes the command queue and the emitter's
// output register, at one word per cycle unless the output stalls.
// A chunk-opening byte first sends its header words, one per cycle unless stalled.
// Reset clears frame state, the queue pointers and the output valid flag; no clearing pass.
// ---------------------------------------------------------------------------
module h264_ps_pes_packetizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [pspes_pkg::FRAME_LEN_W-1:0] frame_length,
    input  logic [pspes_pkg::TS_W-1:0]        pts,
    input  logic                              key_frame,
    input  logic [pspes_pkg::BYTE_W-1:0]      data_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pspes_pkg::DATA_W-1:0]      out_data,
    output logic [pspes_pkg::COUNT_W-1:0]     byte_count,
    output logic                              frame_end,
    output logic                              status,
    output logic                              last_of_run
);

    logic                audio_select_reg;
    logic                q_full;
    logic                push;
    pspes_pkg::pes_cmd_t push_cmd;
    logic                pop;
    pspes_pkg::pes_cmd_t head;
    logic                head_valid;

    // Stream id select register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            audio_select_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            audio_select_reg <= cfg_wr_data;
        end
    end

    // Classifier.
    pspes_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .frame_length (frame_length),
        .pts          (pts),
        .key_frame    (key_frame),
        .data_byte    (data_byte),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // Command queue.
    pspes_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    // Emitter.
    pspes_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .audio_select (audio_select_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .byte_count   (byte_count),
        .frame_end    (frame_end),
        .status       (status),
        .last_of_run  (last_of_run)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream word check of the PS/PES packetizer
// Frame starts and payload bytes go in with random gaps, and the output side
// stalls at random. A local model of the framing state predicts every stream
// word (pack, system, map and PES header words, payload and stray status).
// Each output word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_IDLE       = 19;
    localparam int SETTLE_CYCLES  = 32;
    localparam int RANDOM_ITEMS   = 120;
    localparam int PHASE_ITEMS    = 25;
    localparam int MAX_REPORTS    = 10;
    localparam int HDR_BITS       = 600;
    localparam longint TIMEOUT_CYCLES = 2_000_000;

    // One input word as the driver presents it.
    typedef struct {
        logic                              req;
        logic [pspes_pkg::FRAME_LEN_W-1:0] length;
        logic [pspes_pkg::TS_W-1:0]        stamp;
        logic                              key;
        logic [pspes_pkg::BYTE_W-1:0]      payload;
    } in_word_t;

    // One predicted output word.
    typedef struct {
        logic [pspes_pkg::DATA_W-1:0]  data;
        logic [pspes_pkg::COUNT_W-1:0] count;
        logic                          fend;
        logic                          st;
        logic                          last_flag;
    } stream_word_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic                              cfg_wr_data = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic                              req_type = pspes_pkg::REQ_FRAME_START;
    logic [pspes_pkg::FRAME_LEN_W-1:0] frame_length = '0;
    logic [pspes_pkg::TS_W-1:0]        pts = '0;
    logic                              key_frame = 1'b0;
    logic [pspes_pkg::BYTE_W-1:0]      data_byte = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [pspes_pkg::DATA_W-1:0]      out_data;
    logic [pspes_pkg::COUNT_W-1:0]     byte_count;
    logic                              frame_end;
    logic                              status;
    logic                              last_of_run;

    // Local copy of the framing state and the stream select register.
    int unsigned                frame_left = 0;
    int unsigned                chunk_left = 0;
    logic [pspes_pkg::TS_W-1:0] frame_pts = '0;
    logic                       frame_key = 1'b0;
    logic                       frame_live = 1'b0;
    logic                       audio_sel = 1'b0;

    in_word_t     send_queue[$];
    stream_word_t words_due[$];
    in_word_t     on_wire;
    stream_word_t due;

    int  failures = 0;
    int  items_sent = 0;
    int  words_checked = 0;
    int  chunks_opened = 0;
    int  key_chunks = 0;
    int  strays_dropped = 0;
    int  queued = 0;
    bit  steady_flow = 1'b0;
    bit  gap_armed = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;

    h264_ps_pes_packetizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .frame_length (frame_length),
        .pts          (pts),
        .key_frame    (key_frame),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .byte_count   (byte_count),
        .frame_end    (frame_end),
        .status       (status),
        .last_of_run  (last_of_run)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // A 33-bit timestamp in the marker-bit layout used by PTS and DTS fields.
    function automatic logic [39:0] ts_field(input logic [3:0] prefix,
                                             input logic [pspes_pkg::TS_W-1:0] ts);
        return {prefix, ts[32:30], 1'b1, ts[29:15], 1'b1, ts[14:0], 1'b1};
    endfunction

    function automatic void push_stream_word(input logic [pspes_pkg::DATA_W-1:0] data,
                                             input logic [pspes_pkg::COUNT_W-1:0] count,
                                             input logic fend, input logic st,
                                             input logic last_flag);
        stream_word_t w;
        w.data = data;
        w.count = count;
        w.fend = fend;
        w.st = st;
        w.last_flag = last_flag;
        words_due.push_back(w);
    endfunction

    // Updates the framing state for one accepted word and queues its results.
    function automatic void predict_stream_words(input in_word_t w);
        logic [111:0]                  pack_hdr;
        logic [143:0]                  sys_hdr;
        logic [191:0]                  map_hdr;
        logic [151:0]                  pes_hdr;
        logic [HDR_BITS-1:0]           hdr;
        logic [pspes_pkg::TS_W-1:0]    ts;
        logic [8:0]                    scr_ext;
        logic [15:0]                   pes_len;
        logic [7:0]                    sid;
        logic [pspes_pkg::DATA_W-1:0]  word;
        logic [pspes_pkg::COUNT_W-1:0] cnt;
        logic                          fend;
        int unsigned                   chunk;
        int unsigned                   n_bytes;
        if (w.req == pspes_pkg::REQ_FRAME_START) begin
            // A new start always drops whatever frame was open.
            frame_left = (w.length > pspes_pkg::MAX_FRAME) ? pspes_pkg::MAX_FRAME
                                                           : int'(w.length);
            frame_pts = w.stamp;
            frame_key = w.key;
            chunk_left = 0;
            frame_live = (frame_left != 0);
        end else if (!frame_live || frame_left == 0) begin
            // Payload with no open frame is dropped and flagged.
            frame_live = 1'b0;
            strays_dropped++;
            push_stream_word('0, '0, 1'b0, 1'b1, 1'b1);
        end else begin
            if (chunk_left == 0) begin
                chunk = (frame_left > pspes_pkg::MAX_CHUNK) ? pspes_pkg::MAX_CHUNK
                                                            : frame_left;
                ts = frame_pts;
                scr_ext = 9'(ts % 33'd100);
                pes_len = 16'(chunk + pspes_pkg::PES_LEN_OFFSET);
                sid = audio_sel ? pspes_pkg::SID_AUDIO : pspes_pkg::SID_VIDEO;
                pack_hdr = {32'h000001BA, 2'b01, ts[32:30], 1'b1, ts[29:15], 1'b1,
                            ts[14:0], 1'b1, scr_ext, 1'b1, 22'd255, 2'b11, 5'h1F,
                            3'b000};
                sys_hdr = {32'h000001BB, 16'd12, 1'b1, 22'd50000, 1'b1, 6'd1, 1'b0,
                           1'b1, 1'b1, 1'b1, 1'b1, 5'd1, 1'b0, 7'h7F,
                           pspes_pkg::SID_AUDIO, 2'b11, 1'b0, 13'd512,
                           pspes_pkg::SID_VIDEO, 2'b11, 1'b1, 13'd2048};
                map_hdr = {24'h000001, 8'hBC, 16'd18, 1'b1, 2'b11, 5'd0, 7'h7F, 1'b1,
                           16'd0, 16'd8, 8'h90, pspes_pkg::SID_AUDIO, 16'd0, 8'h1B,
                           pspes_pkg::SID_VIDEO, 16'd0, 32'h45BDDCF4};
                pes_hdr = {24'h000001, sid, pes_len, 2'b10, 6'd0, 1'b1, 1'b1, 6'd0,
                           8'd10, ts_field(4'd3, ts), ts_field(4'd1, ts)};
                if (frame_key) begin
                    hdr = {pack_hdr, sys_hdr, map_hdr, pes_hdr};
                    n_bytes = HDR_BITS / 8;
                    key_chunks++;
                end else begin
                    hdr = {pack_hdr, pes_hdr, 336'd0};
                    n_bytes = ($bits(pack_hdr) + $bits(pes_hdr)) / 8;
                end
                // Header bytes go out four to a word, first byte on top.
                for (int i = 0; i < n_bytes; i += 4) begin
                    word = '0;
                    cnt = '0;
                    for (int j = 0; j < 4; j++) begin
                        word = word << 8;
                        if (i + j < n_bytes) begin
                            word[7:0] = hdr[HDR_BITS - 1 - 8 * (i + j) -: 8];
                            cnt++;
                        end
                    end
                    push_stream_word(word, cnt, 1'b0, 1'b0, 1'b0);
                end
                chunk_left = chunk;
                chunks_opened++;
            end
            chunk_left--;
            frame_left--;
            fend = (frame_left == 0);
            if (fend) begin
                frame_live = 1'b0;
                chunk_left = 0;
            end
            push_stream_word({w.payload, 24'd0}, 3'd1, fend, 1'b0, 1'b1);
        end
    endfunction

    // Input driver: draws a gap before each word, holds the word until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_armed = 1'b0;
            gap_left = 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_stream_words(on_wire);
                items_sent++;
            end
            if (!in_valid || in_ready) begin
                if (!gap_armed && send_queue.size() != 0) begin
                    gap_left = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
                    gap_armed = 1'b1;
                end
                if (gap_armed && gap_left == 0) begin
                    on_wire = send_queue.pop_front();
                    gap_armed = 1'b0;
                    in_valid <= 1'b1;
                    req_type <= on_wire.req;
                    frame_length <= on_wire.length;
                    pts <= on_wire.stamp;
                    key_frame <= on_wire.key;
                    data_byte <= on_wire.payload;
                end else begin
                    in_valid <= 1'b0;
                    if (gap_armed) begin
                        gap_left--;
                    end
                end
            end
        end
    end

    // Output monitor: checks each taken word and stalls at random after it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (words_due.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("unexpected word: data %h count %0d end %b status %b last %b",
                                 out_data, byte_count, frame_end, status, last_of_run);
                    end
                end else begin
                    due = words_due.pop_front();
                    words_checked++;
                    if (out_data !== due.data || byte_count !== due.count ||
                        frame_end !== due.fend || status !== due.st ||
                        last_of_run !== due.last_flag) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("word %0d mismatch: expected %h/%0d/%b/%b/%b got %h/%0d/%b/%b/%b",
                                     words_checked, due.data, due.count, due.fend, due.st,
                                     due.last_flag, out_data, byte_count, frame_end,
                                     status, last_of_run);
                        end
                    end
                end
                stall_left = steady_flow ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [pspes_pkg::TS_W-1:0] random_pts();
        return {1'($urandom_range(0, 1)), 32'($urandom)};
    endfunction

    task automatic queue_frame_start(input int unsigned len,
                                     input logic [pspes_pkg::TS_W-1:0] stamp,
                                     input logic key);
        in_word_t w;
        w.req = pspes_pkg::REQ_FRAME_START;
        w.length = len[pspes_pkg::FRAME_LEN_W-1:0];
        w.stamp = stamp;
        w.key = key;
        w.payload = 8'($urandom);
        send_queue.push_back(w);
        queued++;
    endtask

    // Fields other than the byte carry noise; the block must ignore them.
    task automatic queue_payload(input logic [pspes_pkg::BYTE_W-1:0] value);
        in_word_t w;
        w.req = pspes_pkg::REQ_PAYLOAD;
        w.length = pspes_pkg::FRAME_LEN_W'($urandom);
        w.stamp = random_pts();
        w.key = 1'($urandom_range(0, 1));
        w.payload = value;
        send_queue.push_back(w);
        queued++;
    endtask

    // Mostly whole frames with random content, plus cut, overlong and stray traffic.
    task automatic queue_random_sequence();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 6);
            queue_frame_start(len, random_pts(), 1'($urandom_range(0, 1)));
            repeat (len) queue_payload(8'($urandom));
        end else if (pick < 80) begin
            len = $urandom_range(4, 30);
            queue_frame_start(len, random_pts(), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, len - 1)) queue_payload(8'($urandom));
        end else if (pick < 88) begin
            len = $urandom_range(1, 6);
            queue_frame_start(len, random_pts(), 1'($urandom_range(0, 1)));
            repeat (len + $urandom_range(1, 2)) queue_payload(8'($urandom));
        end else if (pick < 94) begin
            queue_frame_start($urandom_range(0, (1 << pspes_pkg::FRAME_LEN_W) - 1),
                              random_pts(), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3)) queue_payload(8'($urandom));
        end else if (pick < 97) begin
            queue_frame_start(0, random_pts(), 1'($urandom_range(0, 1)));
            queue_payload(8'($urandom));
        end else begin
            queue_payload(8'($urandom));
        end
    endtask

    // Waits until every word is sent and every result is back, then lets
    // the pipeline run dry for a frame start that has no result.
    task automatic settle_pipeline();
        do begin
            @(posedge clk);
        end while (send_queue.size() != 0 || in_valid || words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_audio_select(input logic value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        audio_sel = value;
    endtask

    // Stimulus and verdict.
    initial
    begin
        int unsigned random_queued;
        int unsigned phase_start;
        logic        audio;
        random_queued = 0;
        audio = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        write_audio_select(1'b0);

        // Directed: strays, key and plain chunks, abandoned frames, field extremes.
        queue_payload(8'hFF);
        queue_frame_start(3, '0, 1'b1);
        queue_payload(8'h00);
        queue_payload(8'hA5);
        queue_payload(8'hFF);
        queue_payload(8'h5A);
        queue_frame_start((1 << pspes_pkg::FRAME_LEN_W) - 1, '1, 1'b0);
        queue_payload(8'h12);
        queue_frame_start(0, 33'd99, 1'b1);
        queue_payload(8'h34);
        queue_frame_start(5, 33'd100, 1'b0);
        queue_payload(8'h80);
        queue_frame_start(2, 33'd8589934500, 1'b1);
        queue_payload(8'h01);
        queue_payload(8'hFE);
        queue_frame_start(1, 33'd1048575, 1'b0);
        queue_payload(8'h7F);
        queue_frame_start(pspes_pkg::MAX_FRAME, 33'd12345, 1'b1);
        queue_payload(8'hC3);
        queue_frame_start(1, random_pts(), 1'b1);
        queue_payload(8'h3C);
        settle_pipeline();

        // Random phases, flipping the stream select between them.
        while (random_queued < RANDOM_ITEMS) begin
            write_audio_select(audio);
            audio = ~audio;
            steady_flow = ($urandom_range(0, 4) == 0);
            phase_start = queued;
            while (queued - phase_start < PHASE_ITEMS) begin
                queue_random_sequence();
            end
            random_queued += queued - phase_start;
            settle_pipeline();
        end

        $display("Sent %0d input words and checked %0d stream words.", items_sent,
                 words_checked);
        $display("Opened %0d chunks (%0d key), dropped %0d stray bytes, both stream ids.",
                 chunks_opened, key_chunks, strays_dropped);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures", failures);
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timed out with %0d words to send and %0d results due",
                 send_queue.size(), words_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
